FILE: src/poa_pkg.sv
// Shared types and constants for the polygon angle-order and area block.
// No dependencies.
package poa_pkg;

  localparam int AREA_W = 40;
  localparam int CNT_W  = 7;

  typedef logic [1:0] angle_cls_t;

  localparam angle_cls_t CLS_NEG_Z = 2'd0;
  localparam angle_cls_t CLS_ZERO  = 2'd1;
  localparam angle_cls_t CLS_POS_Z = 2'd2;
  localparam angle_cls_t CLS_PI    = 2'd3;

  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_res_t;

endpackage

FILE: src/poa_cmp.sv
// Shared angle compare unit: quadrant class plus registered cross products.
// Depends on poa_pkg.
module poa_cmp #(
  parameter int DW = 24
) (
  input  logic                 clk,
  input  logic                 load,
  input  logic signed [DW-1:0] ay,
  input  logic signed [DW-1:0] az,
  input  logic signed [DW-1:0] by,
  input  logic signed [DW-1:0] bz,
  output poa_pkg::cmp_res_t    res
);
  import poa_pkg::*;

  localparam int PW = 2 * DW;

  logic signed [PW-1:0] p_azby;
  logic signed [PW-1:0] p_aybz;
  logic signed [PW:0]   diff;
  angle_cls_t           ca;
  angle_cls_t           cb;

  function automatic angle_cls_t cls(input logic signed [DW-1:0] dy,
                                     input logic signed [DW-1:0] dz);
    angle_cls_t c;
    if (dz < 0) c = CLS_NEG_Z;
    else if (dz > 0) c = CLS_POS_Z;
    else if (dy >= 0) c = CLS_ZERO;
    else c = CLS_PI;
    return c;
  endfunction

  always_ff @(posedge clk) begin
    if (load) begin
      p_azby <= PW'(az) * PW'(by);
      p_aybz <= PW'(ay) * PW'(bz);
      ca     <= cls(ay, az);
      cb     <= cls(by, bz);
    end
  end

  always_comb begin
    diff   = (PW + 1)'(p_azby) - (PW + 1)'(p_aybz);
    res.lt = 1'b0;
    res.eq = 1'b0;
    if (ca != cb) begin
      res.lt = (ca < cb);
    end else if (ca == CLS_ZERO || ca == CLS_PI) begin
      res.eq = 1'b1;
    end else begin
      res.lt = diff[PW];
      res.eq = (diff == '0);
    end
  end

endmodule

FILE: src/poa_area.sv
// Shoelace term multiplier and accumulator with absolute value and saturation.
// Depends on poa_pkg.
module poa_area #(
  parameter int CB = 16,
  parameter int NB = 6
) (
  input  logic                        clk,
  input  logic                        clr,
  input  logic                        mul_en,
  input  logic                        acc_en,
  input  logic signed [CB-1:0]        py,
  input  logic signed [CB-1:0]        pz,
  input  logic signed [CB-1:0]        cy,
  input  logic signed [CB-1:0]        cz,
  output logic [poa_pkg::AREA_W-1:0]  area
);
  import poa_pkg::*;

  localparam int PW = 2 * CB + 2;
  localparam int AW = PW + NB;
  localparam int MW = (AW + 1 > AREA_W) ? AW + 1 : AREA_W;

  logic signed [CB:0]   dyv;
  logic signed [CB:0]   szv;
  logic signed [PW-1:0] prod;
  logic signed [AW-1:0] acc;
  logic [AW:0]          mag;
  logic [MW-1:0]        mag_w;

  assign dyv = (CB + 1)'(py) - (CB + 1)'(cy);
  assign szv = (CB + 1)'(pz) + (CB + 1)'(cz);

  always_ff @(posedge clk) begin
    if (mul_en) prod <= PW'(dyv) * PW'(szv);
    if (clr) acc <= '0;
    else if (acc_en) acc <= acc + AW'(prod);
  end

  always_comb begin
    mag   = acc[AW-1] ? -((AW + 1)'(acc)) : (AW + 1)'(acc);
    mag_w = MW'(mag);
    area  = (mag_w > MW'({AREA_W{1'b1}})) ? {AREA_W{1'b1}} : mag_w[AREA_W-1:0];
  end

endmodule

FILE: src/polygon_angle_order_and_area.sv
// Top level: vertex store, sequencer, angle sort and area of one polygon.
// Depends on poa_pkg, poa_cmp and poa_area.
//
// Input stream s_axis: one vertex (y, z) per item, tlast marks the final
// vertex of a polygon. Vertices load one per cycle; beyond MAX_VERTICES
// they are dropped and the overflow flag is raised for that polygon.
// After the last vertex the block stops taking items and works on its own:
// it forms the offsets from the centroid one vertex at a time, then makes two
// passes over vertex pairs through one shared compare unit, skipping pairs
// that do not apply, then primes and sums the area over the kept vertices
// and then emits one result for each kept vertex in angle order.
// Output stream m_axis: kept vertices in ascending angle about the centroid,
// each with the kept count and overflow flag; tlast and twice the area sit on
// the final one. A stalled receiver holds the output register and the
// sequencer; loading of the next polygon starts after the final result.
// Reset clears the load count, sums, overflow flag and output valid.
module polygon_angle_order_and_area #(
  parameter int MAX_VERTICES = 32,
  parameter int COORD_BITS   = 16,
  localparam int IN_W  = ((2 * COORD_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((2 * COORD_BITS + poa_pkg::AREA_W + poa_pkg::CNT_W + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [IN_W-1:0]  s_axis_tdata,   // vertex_y, vertex_z
  input  logic             s_axis_tlast,   // last_vertex
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [OUT_W-1:0] m_axis_tdata,   // out_y, out_z, area_twice, vertex_count
  output logic             m_axis_tuser,   // overflow
  output logic             m_axis_tlast    // last
);
  import poa_pkg::*;

  localparam int NB = $clog2(MAX_VERTICES + 1);
  localparam int IW = $clog2(MAX_VERTICES);
  localparam int SW = COORD_BITS + NB;
  localparam int DW = SW + 1;

  typedef enum logic [3:0] {
    S_LOAD, S_DREAD, S_DWRITE, S_PREAD, S_PMUL, S_PRES,
    S_AORD, S_ASTO, S_AMUL, S_AACC, S_EORD, S_ESTO, S_ELOAD, S_EOUT
  } state_t;

  state_t state;

  logic [NB-1:0]                cnt;
  logic signed [SW-1:0]         sum_y;
  logic signed [SW-1:0]         sum_z;
  logic                         ovf;
  logic [IW-1:0]                i;
  logic [IW-1:0]                j;
  logic [IW-1:0]                k;
  logic                         keep_phase;
  logic [MAX_VERTICES-1:0]      keep;
  logic [NB-1:0]                rank;
  logic [NB-1:0]                kept;
  logic                         prime;
  logic signed [COORD_BITS-1:0] py;
  logic signed [COORD_BITS-1:0] pz;

  logic signed [COORD_BITS-1:0] store_y [MAX_VERTICES];
  logic signed [COORD_BITS-1:0] store_z [MAX_VERTICES];
  logic signed [DW-1:0]         delta_y [MAX_VERTICES];
  logic signed [DW-1:0]         delta_z [MAX_VERTICES];
  logic [IW-1:0]                order   [MAX_VERTICES];

  logic signed [COORD_BITS-1:0] sy_q;
  logic signed [COORD_BITS-1:0] sz_q;
  logic signed [DW-1:0]         da_y;
  logic signed [DW-1:0]         da_z;
  logic signed [DW-1:0]         db_y;
  logic signed [DW-1:0]         db_z;
  logic [IW-1:0]                ord_q;

  logic signed [COORD_BITS-1:0] oy;
  logic signed [COORD_BITS-1:0] oz;
  logic [AREA_W-1:0]            o_area;
  logic [CNT_W-1:0]             o_cnt;
  logic                         o_ovf;
  logic                         o_last;

  logic signed [COORD_BITS-1:0] vy;
  logic signed [COORD_BITS-1:0] vz;
  logic                         accept;
  logic                         room;
  logic [NB-1:0]                cnt_m1;
  logic [NB-1:0]                kept_m1;
  logic                         last_i;
  logic                         last_j;
  logic                         applies;
  logic                         adv;
  logic                         hit;
  logic [NB-1:0]                rank_acc;
  logic                         ord_we;
  logic                         st_we;
  logic                         dl_we;
  logic [IW-1:0]                st_raddr;
  logic [IW-1:0]                ord_raddr;
  logic signed [SW-1:0]         ny;
  logic signed [SW-1:0]         nz;
  logic signed [DW-1:0]         dly;
  logic signed [DW-1:0]         dlz;
  logic                         area_clr;
  logic [AREA_W-1:0]            area;
  cmp_res_t                     cres;

  assign vy = s_axis_tdata[COORD_BITS-1:0];
  assign vz = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];

  assign s_axis_tready = (state == S_LOAD);
  assign accept        = s_axis_tvalid & s_axis_tready;
  assign room          = (cnt < NB'(MAX_VERTICES));
  assign cnt_m1        = cnt - NB'(1);
  assign kept_m1       = kept - NB'(1);
  assign last_i        = (NB'(i) == cnt_m1);
  assign last_j        = (NB'(j) == cnt_m1);
  assign applies       = keep_phase ? (j > i) : (keep[i] & keep[j] & (j != i));
  assign adv           = (state == S_PREAD && !applies) || (state == S_PRES);
  assign hit           = (state == S_PRES) && (keep_phase ? cres.eq : cres.lt);
  assign rank_acc      = rank + NB'(hit);
  assign ord_we        = adv && last_j && !keep_phase && keep[i];
  assign area_clr      = adv && last_j && last_i && !keep_phase;
  assign st_we         = accept && room;
  assign dl_we         = (state == S_DWRITE);
  assign st_raddr      = (state == S_DREAD) ? i : ord_q;
  assign ord_raddr     = (state == S_AORD && prime) ? kept_m1[IW-1:0] : k;

  assign ny  = SW'($signed({1'b0, cnt})) * SW'(sy_q);
  assign nz  = SW'($signed({1'b0, cnt})) * SW'(sz_q);
  assign dly = DW'(ny) - DW'(sum_y);
  assign dlz = DW'(nz) - DW'(sum_z);

  always_ff @(posedge clk) begin
    if (st_we) begin
      store_y[cnt[IW-1:0]] <= vy;
      store_z[cnt[IW-1:0]] <= vz;
    end
    sy_q <= store_y[st_raddr];
    sz_q <= store_z[st_raddr];
  end

  always_ff @(posedge clk) begin
    if (dl_we) begin
      delta_y[i] <= dly;
      delta_z[i] <= dlz;
    end
    da_y <= delta_y[i];
    da_z <= delta_z[i];
    db_y <= delta_y[j];
    db_z <= delta_z[j];
  end

  always_ff @(posedge clk) begin
    if (ord_we) order[rank_acc[IW-1:0]] <= i;
    ord_q <= order[ord_raddr];
  end

  poa_cmp #(.DW(DW)) u_cmp (
    .clk  (clk),
    .load (state == S_PMUL),
    .ay   (db_y),
    .az   (db_z),
    .by   (da_y),
    .bz   (da_z),
    .res  (cres)
  );

  poa_area #(.CB(COORD_BITS), .NB(NB)) u_area (
    .clk    (clk),
    .clr    (area_clr),
    .mul_en (state == S_AMUL && !prime),
    .acc_en (state == S_AACC),
    .py     (py),
    .pz     (pz),
    .cy     (sy_q),
    .cz     (sz_q),
    .area   (area)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_LOAD;
      cnt           <= '0;
      sum_y         <= '0;
      sum_z         <= '0;
      ovf           <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      case (state)
        S_LOAD: begin
          if (accept) begin
            if (room) begin
              cnt   <= cnt + NB'(1);
              sum_y <= sum_y + SW'(vy);
              sum_z <= sum_z + SW'(vz);
            end else begin
              ovf <= 1'b1;
            end
            if (s_axis_tlast) begin
              i     <= '0;
              state <= S_DREAD;
            end
          end
        end
        S_DREAD: state <= S_DWRITE;
        S_DWRITE: begin
          if (last_i) begin
            i          <= '0;
            j          <= '0;
            keep       <= '1;
            keep_phase <= 1'b1;
            rank       <= '0;
            kept       <= '0;
            state      <= S_PREAD;
          end else begin
            i     <= i + IW'(1);
            state <= S_DREAD;
          end
        end
        S_PREAD: if (applies) state <= S_PMUL;
        S_PMUL:  state <= S_PRES;
        S_PRES:  state <= S_PREAD;
        S_AORD:  state <= S_ASTO;
        S_ASTO:  state <= S_AMUL;
        S_AMUL: begin
          py <= sy_q;
          pz <= sz_q;
          if (prime) begin
            prime <= 1'b0;
            state <= S_AORD;
          end else begin
            state <= S_AACC;
          end
        end
        S_AACC: begin
          if (NB'(k) == kept_m1) begin
            k     <= '0;
            state <= S_EORD;
          end else begin
            k     <= k + IW'(1);
            state <= S_AORD;
          end
        end
        S_EORD: state <= S_ESTO;
        S_ESTO: state <= S_ELOAD;
        S_ELOAD: begin
          oy            <= sy_q;
          oz            <= sz_q;
          o_last        <= (NB'(k) == kept_m1);
          o_area        <= (NB'(k) == kept_m1) ? area : '0;
          o_cnt         <= CNT_W'(kept);
          o_ovf         <= ovf;
          m_axis_tvalid <= 1'b1;
          state         <= S_EOUT;
        end
        S_EOUT: begin
          if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
            if (o_last) begin
              cnt   <= '0;
              sum_y <= '0;
              sum_z <= '0;
              ovf   <= 1'b0;
              state <= S_LOAD;
            end else begin
              k     <= k + IW'(1);
              state <= S_EORD;
            end
          end
        end
        default: state <= S_LOAD;
      endcase

      if (adv) begin
        if (keep_phase && hit) keep[i] <= 1'b0;
        if (last_j) begin
          if (!keep_phase && keep[i]) kept <= kept + NB'(1);
          rank <= '0;
          j    <= '0;
          if (last_i) begin
            i <= '0;
            if (keep_phase) begin
              keep_phase <= 1'b0;
              state      <= S_PREAD;
            end else begin
              k     <= '0;
              prime <= 1'b1;
              state <= S_AORD;
            end
          end else begin
            i     <= i + IW'(1);
            state <= S_PREAD;
          end
        end else begin
          j     <= j + IW'(1);
          rank  <= rank_acc;
          state <= S_PREAD;
        end
      end
    end
  end

  assign m_axis_tdata = OUT_W'({o_cnt, o_area, oz, oy});
  assign m_axis_tuser = o_ovf;
  assign m_axis_tlast = o_last;

  a_valid_in_emit: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> state == S_EOUT)
    else $error("output valid outside emit state");

  a_no_load_while_out: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !m_axis_tvalid)
    else $error("input ready while a result waits");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= NB'(MAX_VERTICES))
    else $error("load count beyond store depth");

  a_kept_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_EOUT |-> (kept != '0 && kept <= cnt))
    else $error("kept count out of range during emit");

endmodule

FILE: tb/tb.sv
// Testbench for polygon_angle_order_and_area: streams polygons, predicts the
// angle-ordered vertices and twice the shoelace area, and checks each result.
// Depends on poa_pkg and the block's RTL.
module tb;
  import poa_pkg::*;

  localparam int MAXV = 32;
  localparam int IN_W = 32;
  localparam int OUT_W = 80;
  localparam int WATCHDOG = 100000;

  typedef struct {
    logic [15:0] y;
    logic [15:0] z;
    logic [AREA_W-1:0] area;
    logic [CNT_W-1:0] cnt;
    logic ovf;
    logic fin;
  } vtx_out_t;

  logic clk = 0;
  logic rst = 1;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic s_axis_tlast = 0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [OUT_W-1:0] m_axis_tdata;
  logic m_axis_tuser;
  logic m_axis_tlast;

  polygon_angle_order_and_area DUT (.*);

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  vtx_out_t ordered_q[$];
  longint poly_y[MAXV];
  longint poly_z[MAXV];
  int poly_n = 0;
  longint poly_sy = 0;
  longint poly_sz = 0;
  bit poly_ovf = 0;
  int errors = 0;
  int send_idle = 0;
  int recv_stall = 0;
  int hold_off = 0;
  int quiet = 0;

  function automatic int quad(longint dy, longint dz);
    if (dz < 0) return CLS_NEG_Z;
    if (dz > 0) return CLS_POS_Z;
    return (dy >= 0) ? CLS_ZERO : CLS_PI;
  endfunction

  // -1 if angle a below angle b, 0 if equal, 1 if above
  function automatic int angle_order(longint ay, longint az, longint by, longint bz);
    int ca, cb;
    logic signed [127:0] p, q;
    ca = quad(ay, az);
    cb = quad(by, bz);
    if (ca != cb) return (ca < cb) ? -1 : 1;
    if (ca == CLS_ZERO || ca == CLS_PI) return 0;
    p = 128'(ay) * 128'(bz);
    q = 128'(az) * 128'(by);
    if (p == q) return 0;
    return (p > q) ? -1 : 1;
  endfunction

  task automatic predict_vertex(logic [15:0] y, logic [15:0] z, logic fin);
    longint dy[MAXV], dz[MAXV];
    bit keep[MAXV];
    int order[MAXV];
    int kept, rank, c, p;
    logic signed [127:0] acc;
    logic [AREA_W-1:0] area;
    vtx_out_t o;
    if (poly_n < MAXV) begin
      poly_y[poly_n] = longint'($signed(y));
      poly_z[poly_n] = longint'($signed(z));
      poly_sy += poly_y[poly_n];
      poly_sz += poly_z[poly_n];
      poly_n++;
    end else begin
      poly_ovf = 1;
    end
    if (!fin) return;
    kept = 0;
    for (int i = 0; i < poly_n; i++) begin
      dy[i] = poly_n * poly_y[i] - poly_sy;
      dz[i] = poly_n * poly_z[i] - poly_sz;
    end
    for (int i = 0; i < poly_n; i++) begin
      keep[i] = 1;
      for (int j = i + 1; j < poly_n; j++)
        if (angle_order(dy[i], dz[i], dy[j], dz[j]) == 0) keep[i] = 0;
      if (keep[i]) kept++;
    end
    for (int i = 0; i < poly_n; i++) begin
      if (!keep[i]) continue;
      rank = 0;
      for (int j = 0; j < poly_n; j++)
        if (keep[j] && angle_order(dy[j], dz[j], dy[i], dz[i]) < 0) rank++;
      order[rank] = i;
    end
    acc = 0;
    for (int k = 0; k < kept; k++) begin
      c = order[k];
      p = order[(k == 0) ? kept - 1 : k - 1];
      acc += 128'(poly_y[p] - poly_y[c]) * 128'(poly_z[p] + poly_z[c]);
    end
    if (acc < 0) acc = -acc;
    area = (acc > 128'((64'd1 << 40) - 1)) ? '1 : acc[AREA_W-1:0];
    for (int k = 0; k < kept; k++) begin
      o.y = poly_y[order[k]][15:0];
      o.z = poly_z[order[k]][15:0];
      o.fin = (k + 1 == kept);
      o.area = o.fin ? area : '0;
      o.cnt = kept[CNT_W-1:0];
      o.ovf = poly_ovf;
      ordered_q = {ordered_q, o};
    end
    poly_n = 0;
    poly_sy = 0;
    poly_sz = 0;
    poly_ovf = 0;
  endtask

  task automatic send_vertex(logic [15:0] y, logic [15:0] z, logic fin);
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= {z, y};
    s_axis_tlast <= fin;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_vertex(y, z, fin);
  endtask

  task automatic send_polygon(int n, int span);
    for (int i = 0; i < n; i++)
      send_vertex(16'($urandom_range(2 * span) - span), 16'($urandom_range(2 * span) - span),
                  i == n - 1);
  endtask

  task automatic drain;
    s_axis_tvalid <= 0;
    while (ordered_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_axis_tready <= 0;
    end else begin
      m_axis_tready <= !(recv_stall > 0 && $urandom_range(99) < recv_stall);
    end
  end

  always @(posedge clk) begin
    vtx_out_t e;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (ordered_q.size() == 0) begin
        $error("unexpected result %h", m_axis_tdata);
        errors++;
      end else begin
        e = ordered_q.pop_front();
        if (m_axis_tdata[15:0] !== e.y) begin
          $error("out_y exp %h got %h", e.y, m_axis_tdata[15:0]); errors++;
        end
        if (m_axis_tdata[31:16] !== e.z) begin
          $error("out_z exp %h got %h", e.z, m_axis_tdata[31:16]); errors++;
        end
        if (m_axis_tdata[71:32] !== e.area) begin
          $error("area_twice exp %h got %h", e.area, m_axis_tdata[71:32]); errors++;
        end
        if (m_axis_tdata[78:72] !== e.cnt) begin
          $error("vertex_count exp %0d got %0d", e.cnt, m_axis_tdata[78:72]); errors++;
        end
        if (m_axis_tuser !== e.ovf) begin
          $error("overflow exp %b got %b", e.ovf, m_axis_tuser); errors++;
        end
        if (m_axis_tlast !== e.fin) begin
          $error("last exp %b got %b", e.fin, m_axis_tlast); errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WATCHDOG) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic test_extremes;
    send_vertex(16'h8000, 16'h8000, 0);
    send_vertex(16'h7fff, 16'h8000, 0);
    send_vertex(16'h7fff, 16'h7fff, 0);
    send_vertex(16'h8000, 16'h7fff, 1);
    send_vertex(16'h1234, 16'hedcb, 1);
    send_vertex(16'h0000, 16'h0000, 0);
    send_vertex(16'hffff, 16'hffff, 1);
  endtask

  task automatic test_angle_classes;
    send_vertex(16'd10, 16'd0, 0);
    send_vertex(16'd0, 16'd10, 0);
    send_vertex(-16'sd10, 16'd0, 0);
    send_vertex(16'd0, -16'sd10, 0);
    send_vertex(16'd0, 16'd0, 1);
    send_vertex(16'd1, 16'd1, 0);
    send_vertex(16'd2, 16'd2, 0);
    send_vertex(16'd3, 16'd3, 0);
    send_vertex(-16'sd6, 16'd5, 1);
  endtask

  task automatic test_overflow;
    send_polygon(MAXV + 3, 2000);
    drain();
  endtask

  task automatic test_random(int polys, int idle, int stall);
    send_idle = idle;
    recv_stall = stall;
    for (int p = 0; p < polys; p++) begin
      if ($urandom_range(9) == 0) send_polygon($urandom_range(1, 2), 30000);
      else if ($urandom_range(9) == 0) send_polygon($urandom_range(3, 6), 4);
      else send_polygon($urandom_range(3, 8), 32767);
    end
    drain();
  endtask

  task automatic test_backpressure;
    send_idle = 0;
    recv_stall = 0;
    @(posedge clk);
    hold_off = 400;
    send_polygon(4, 32767);
    send_polygon(5, 32767);
    drain();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_extremes();
    test_angle_classes();
    drain();
    test_overflow();
    test_random(8, 0, 0);
    test_random(8, 67, 0);
    test_random(8, 0, 67);
    test_random(8, 25, 25);
    test_backpressure();
    if (errors == 0 && ordered_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
